/* design/rgvw_pkg.sv */
// ----------------------------------------------------------------------------
// rgvw_pkg
// Shared types, constants and helpers of the ray grid voxel walker.
// ----------------------------------------------------------------------------
package rgvw_pkg;

	// Grid limits
	localparam int MAX_CELLS_PER_AXIS = 256;
	localparam int CELL_W             = 8;
	localparam int CNT_W              = 9;
	localparam int TIME_W             = 31;
	localparam logic [TIME_W-1:0] TMAX = 31'h7FFF_FFFF;

	// Divider port widths
	localparam int NUM_W = 48;
	localparam int DEN_W = 32;
	localparam int QUO_W = 32;
	localparam int REM_W = 64;

	// Last axis (z)
	localparam logic [1:0] LAST_AXIS = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] CFG_MIN_X  = 3'd0;
	localparam logic [2:0] CFG_MIN_Y  = 3'd1;
	localparam logic [2:0] CFG_MIN_Z  = 3'd2;
	localparam logic [2:0] CFG_SIZE_X = 3'd3;
	localparam logic [2:0] CFG_SIZE_Y = 3'd4;
	localparam logic [2:0] CFG_SIZE_Z = 3'd5;
	localparam logic [2:0] CFG_CELLS  = 3'd6;

	typedef enum logic [1:0] {
		WS_VOXEL = 2'd0,
		WS_MISS  = 2'd1,
		WS_LEFT  = 2'd2,
		WS_NOACT = 2'd3
	} walk_status_t;

	// What a division computes and where its quotient goes
	typedef enum logic [2:0] {
		DOP_T0,
		DOP_T1,
		DOP_CELL,
		DOP_CT,
		DOP_BT
	} div_op_t;

	// Axis choice from the three boundary compares
	localparam logic [1:0] AXIS_PICK [8] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd2, 2'd1, 2'd0};

	function automatic logic [1:0] pick_axis(input logic [TIME_W-1:0] b0,
		input logic [TIME_W-1:0] b1, input logic [TIME_W-1:0] b2);
		logic [2:0] sel;
		sel = {(b2 <= b0), (b1 <= b2), (b0 <= b1)};
		return AXIS_PICK[sel];
	endfunction

	// Controller to datapath commands
	typedef struct packed {
		logic         cap;
		logic         init;
		logic         nsz;
		logic         zero_chk;
		logic         div_start;
		div_op_t      div_op;
		logic         mul_hi;
		logic         mul_lo;
		logic         rel;
		logic         cell_dir;
		logic         tgt;
		logic         commit;
		logic         step;
		logic         em1;
		logic         em2;
		logic         out_load;
		walk_status_t out_kind;
		logic [1:0]   axis;
	} rgvw_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic req_start;
		logic h_zero;
		logic miss;
		logic cell_direct;
		logic active;
		logic edge_hit;
		logic out_free;
		logic div_done;
		logic div_busy;
	} rgvw_stat_t;

endpackage

/* design/ray_grid_voxel_walker.sv */
// ----------------------------------------------------------------------------
// ray_grid_voxel_walker
// Walks a ray through a uniform 3D voxel grid: start items clip the ray
// against the grid box and report the entry voxel, step items cross the
// nearest voxel boundary and report the next voxel or the grid exit.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  s_*      | in        | tuser: req_type; tdata: origin xyz, heading xyz
//  m_*      | out       | tuser: walk_status; tdata: index, cell xyz, times
//  cfg_*    | in        | register write, index 0..6, no read-back
//
// A step item runs through the axis pick, the index multiplies and the
// result register. A start item runs the shared one-bit-per-cycle
// divider up to fifteen times. One item is worked on at a time; a
// finished result waits in the output register while the next item is
// accepted. Reset is asynchronous, active low, and leaves no ray active.
// ----------------------------------------------------------------------------
module ray_grid_voxel_walker import rgvw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,   // origin_x, origin_y, origin_z, heading_x, heading_y, heading_z
	input  logic         s_tuser,   // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // cell_index, cell_x, cell_y, cell_z, span_enter, span_leave,
	                                // box_exit, zero fill
	output logic [1:0]   m_tuser    // walk_status
);

	rgvw_cmd_t  cmd;
	rgvw_stat_t st;

	rgvw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	rgvw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.st        (st)
	);

`ifndef SYNTH
	// No new item while a division is still running
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !st.div_busy) else $error("item accepted during division");

	// Divider started only when free
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !st.div_busy) else $error("divider restarted while busy");

	// Result register loaded only when empty or draining
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready)) else $error("result overwritten");

	// A grid exit reports one time for both span ends
	a_left_span: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == WS_LEFT) |-> (m_tdata[78:48] == m_tdata[109:79]))
		else $error("grid exit span mismatch");
`endif

endmodule

/* design/rgvw_div.sv */
// ----------------------------------------------------------------------------
// rgvw_div
// Shared restoring divider, one quotient bit per cycle. Q16 mode gives
// floor(num * 2^16 / den) saturated to 2^31; integer mode gives an 8-bit
// quotient for a dividend known to stay below den * 256.
// ----------------------------------------------------------------------------
module rgvw_div import rgvw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             frac,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [QUO_W-1:0] quot
);

	localparam logic [4:0] FRAC_LAST = 5'd30;
	localparam logic [4:0] INT_LAST  = 5'd7;

	logic             busy_q, done_q;
	logic [4:0]       cnt_q;
	logic [REM_W-1:0] rem_q, dvs_q;
	logic [QUO_W-1:0] quot_q;
	logic             sat_w, ge_w;

	// Quotient of 2^31 or more saturates
	assign sat_w = frac && (num >= {1'b0, den, 15'b0});
	assign ge_w  = rem_q >= dvs_q;

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !sat_w;
				done_q <= sat_w;
				cnt_q  <= frac ? FRAC_LAST : INT_LAST;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	// Subtract and shift
	always_ff @(posedge clk) begin
		if (start) begin
			if (sat_w) begin
				quot_q <= {1'b1, {(QUO_W-1){1'b0}}};
			end else begin
				rem_q  <= frac ? {num, 16'b0} : {16'b0, num};
				dvs_q  <= frac ? {2'b0, den, 30'b0} : {25'b0, den, 7'b0};
				quot_q <= '0;
			end
		end else if (busy_q) begin
			rem_q  <= ge_w ? rem_q - dvs_q : rem_q;
			quot_q <= {quot_q[QUO_W-2:0], ge_w};
			dvs_q  <= dvs_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;

endmodule

/* design/rgvw_ctrl.sv */
// ----------------------------------------------------------------------------
// rgvw_ctrl
// Sequencer of the voxel walker: ray setup over the three axes with the
// shared divider, voxel steps, index build and result hand-off.
// ----------------------------------------------------------------------------
module rgvw_ctrl import rgvw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  rgvw_stat_t st,
	output rgvw_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_SHI, S_SLAB, S_SLAB1, S_SNEXT, S_CHK,
		S_CHI, S_MH, S_ML, S_REL, S_CELL, S_TG, S_BT, S_CNEXT,
		S_STEP, S_E1, S_E2, S_OUT, S_DIVW
	} state_t;

	state_t       state_q, ret_q;
	logic [1:0]   ax_q;
	walk_status_t kind_q;

	assign s_tready = (state_q == S_IDLE);

	// Decode commands
	always_comb begin
		cmd          = '0;
		cmd.axis     = ax_q;
		cmd.out_kind = kind_q;
		cmd.div_op   = DOP_T0;
		case (state_q)
			S_IDLE:       cmd.cap = s_tvalid;
			S_INIT:       cmd.init = 1'b1;
			S_SHI, S_CHI: cmd.nsz = 1'b1;
			S_SLAB: begin
				if (st.h_zero) begin
					cmd.zero_chk = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DOP_T0;
				end
			end
			S_SLAB1: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DOP_T1;
			end
			S_MH:  cmd.mul_hi = 1'b1;
			S_ML:  cmd.mul_lo = 1'b1;
			S_REL: cmd.rel = 1'b1;
			S_CELL: begin
				if (st.cell_direct) begin
					cmd.cell_dir = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DOP_CELL;
				end
			end
			S_TG: begin
				cmd.tgt = 1'b1;
				if (!st.h_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_op    = DOP_CT;
				end
			end
			S_BT: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DOP_BT;
			end
			S_CNEXT: cmd.commit = (ax_q == LAST_AXIS);
			S_STEP:  cmd.step = st.active;
			S_E1:    cmd.em1 = 1'b1;
			S_E2:    cmd.em2 = 1'b1;
			S_OUT:   cmd.out_load = st.out_free;
			default: ;
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			ax_q    <= '0;
			kind_q  <= WS_VOXEL;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= st.req_start ? S_INIT : S_STEP;
				end
				S_INIT: begin
					ax_q    <= '0;
					state_q <= S_SHI;
				end
				S_SHI: state_q <= S_SLAB;
				S_SLAB: begin
					if (st.h_zero) begin
						state_q <= S_SNEXT;
					end else begin
						ret_q   <= S_SLAB1;
						state_q <= S_DIVW;
					end
				end
				S_SLAB1: begin
					ret_q   <= S_SNEXT;
					state_q <= S_DIVW;
				end
				S_SNEXT: begin
					if (ax_q == LAST_AXIS) begin
						ax_q    <= '0;
						state_q <= S_CHK;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_SHI;
					end
				end
				S_CHK: begin
					if (st.miss) begin
						kind_q  <= WS_MISS;
						state_q <= S_OUT;
					end else begin
						state_q <= S_CHI;
					end
				end
				S_CHI: state_q <= S_MH;
				S_MH:  state_q <= S_ML;
				S_ML:  state_q <= S_REL;
				S_REL: state_q <= S_CELL;
				S_CELL: begin
					if (st.cell_direct) begin
						state_q <= S_TG;
					end else begin
						ret_q   <= S_TG;
						state_q <= S_DIVW;
					end
				end
				S_TG: begin
					if (st.h_zero) begin
						state_q <= S_CNEXT;
					end else begin
						ret_q   <= S_BT;
						state_q <= S_DIVW;
					end
				end
				S_BT: begin
					ret_q   <= S_CNEXT;
					state_q <= S_DIVW;
				end
				S_CNEXT: begin
					if (ax_q == LAST_AXIS) begin
						state_q <= S_E1;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_CHI;
					end
				end
				S_STEP: begin
					if (!st.active) begin
						kind_q  <= WS_NOACT;
						state_q <= S_OUT;
					end else if (st.edge_hit) begin
						kind_q  <= WS_LEFT;
						state_q <= S_OUT;
					end else begin
						state_q <= S_E1;
					end
				end
				S_E1: state_q <= S_E2;
				S_E2: begin
					kind_q  <= WS_VOXEL;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (st.out_free) state_q <= S_IDLE;
				end
				S_DIVW: begin
					if (st.div_done) state_q <= ret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* design/rgvw_dp.sv */
// ----------------------------------------------------------------------------
// rgvw_dp
// Datapath of the voxel walker: configuration and ray registers, slab
// test, entry voxel, per-axis times, step update and the result register.
// ----------------------------------------------------------------------------
module rgvw_dp import rgvw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic [191:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tready,
	output logic         m_tvalid,
	output logic [143:0] m_tdata,
	output logic [1:0]   m_tuser,
	input  rgvw_cmd_t    cmd,
	output rgvw_stat_t   st
);

	// Configuration
	logic signed [31:0] min_q [3];
	logic [30:0]        size_q [3];
	logic [23:0]        cells_q;

	// Ray input
	logic signed [31:0] o_q [3];
	logic signed [31:0] h_q [3];

	// Walk state
	logic               active_q;
	logic [CELL_W-1:0]  cell_q [3];
	logic               neg_q [3];
	logic [TIME_W-1:0]  bt_q [3];
	logic [TIME_W-1:0]  ct_q [3];
	logic [TIME_W-1:0]  enter_q, exit_q;

	// Setup scratch
	logic signed [32:0] tn_q, tf_q, t0_q;
	logic               miss_q;
	logic [39:0]        nsz_q;
	logic [47:0]        prod_q;
	logic signed [49:0] rel_q;
	logic signed [41:0] tgt_q;
	div_op_t            dop_q;
	logic               dneg_q;

	// Result build
	logic [TIME_W-1:0]  lv_q;
	logic [16:0]        m1_q;
	logic [23:0]        idx_q;
	logic               mv_q;
	logic [1:0]         mu_q;
	logic [143:0]       md_q;

	// Per-axis effective size and count
	logic [30:0]        sz_w [3];
	logic [CNT_W-1:0]   cnt_w [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic [CNT_W-1:0] raw;
			raw      = {1'b0, cells_q[8*a +: 8]} + 9'd1;
			cnt_w[a] = (raw > CNT_W'(MAX_CELLS_PER_AXIS)) ? CNT_W'(MAX_CELLS_PER_AXIS) : raw;
			sz_w[a]  = (size_q[a] == '0) ? 31'd1 : size_q[a];
		end
	end

	// Selected axis operands
	logic [1:0]         ax;
	logic signed [31:0] lo_a, o_a, h_a;
	logic [30:0]        sz_a;
	logic [CNT_W-1:0]   cnt_a;
	logic [31:0]        hmag;
	logic               h_zero, pos_w;
	logic signed [41:0] lo42, o42, hi_w;

	assign ax     = cmd.axis;
	assign lo_a   = min_q[ax];
	assign o_a    = o_q[ax];
	assign h_a    = h_q[ax];
	assign sz_a   = sz_w[ax];
	assign cnt_a  = cnt_w[ax];
	assign h_zero = (h_a == '0);
	assign pos_w  = !h_a[31] && !h_zero;
	assign hmag   = h_a[31] ? (~h_a + 32'd1) : h_a;
	assign lo42   = {{10{lo_a[31]}}, lo_a};
	assign o42    = {{10{o_a[31]}}, o_a};
	assign hi_w   = lo42 + $signed({2'b0, nsz_q});

	// Divider operands
	logic               dv_start, dv_frac, dv_busy, dv_done, dneg_d;
	logic [NUM_W-1:0]   dv_num;
	logic [DEN_W-1:0]   dv_den;
	logic [QUO_W-1:0]   dv_quot;
	logic signed [41:0] num_s;
	logic [41:0]        num_mag;

	assign dv_start = cmd.div_start;
	assign num_mag  = num_s[41] ? 42'(-num_s) : 42'(num_s);

	always_comb begin
		num_s   = lo42 - o42;
		dv_frac = 1'b1;
		dv_den  = hmag;
		dv_num  = {6'b0, num_mag};
		dneg_d  = num_s[41] ^ h_a[31];
		case (cmd.div_op)
			DOP_T0: num_s = lo42 - o42;
			DOP_T1: begin
				num_s  = hi_w - o42;
				dv_num = {6'b0, num_mag};
				dneg_d = num_s[41] ^ h_a[31];
			end
			DOP_BT: begin
				num_s  = tgt_q - o42;
				dv_num = {6'b0, num_mag};
				dneg_d = num_s[41] ^ h_a[31];
			end
			DOP_CT: begin
				dv_num = {17'b0, sz_a};
				dneg_d = 1'b0;
			end
			DOP_CELL: begin
				dv_frac = 1'b0;
				dv_num  = rel_q[47:0];
				dv_den  = {1'b0, sz_a};
				dneg_d  = 1'b0;
			end
			default: ;
		endcase
	end

	rgvw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.frac   (dv_frac),
		.num    (dv_num),
		.den    (dv_den),
		.busy   (dv_busy),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	// Signed quotient and slab bounds
	logic signed [32:0] sq_w, nn_w, ff_w, tmax33;

	assign tmax33 = $signed({2'b0, TMAX});
	assign sq_w   = dneg_q ? -$signed({1'b0, dv_quot}) : $signed({1'b0, dv_quot});
	assign nn_w   = (t0_q < sq_w) ? t0_q : sq_w;
	assign ff_w   = (t0_q < sq_w) ? sq_w : t0_q;

	// Products for the entry point and boundary target
	logic [30:0]        t_w;
	logic [46:0]        mh_w, ml_w;
	logic signed [49:0] d50;
	logic [8:0]         k_w;
	logic [39:0]        kp_w, nsz_w;

	assign t_w   = tn_q[30:0];
	assign mh_w  = {16'b0, t_w} * {31'b0, hmag[31:16]};
	assign ml_w  = {16'b0, t_w} * {31'b0, hmag[15:0]};
	assign d50   = $signed({{18{o_a[31]}}, o_a}) - $signed({{18{lo_a[31]}}, lo_a});
	assign k_w   = {1'b0, cell_q[ax]} + {8'b0, pos_w};
	assign kp_w  = {31'b0, k_w} * {9'b0, sz_a};
	assign nsz_w = {31'b0, cnt_a} * {9'b0, sz_a};

	// Step: nearest boundary
	logic [1:0]        sel_w;
	logic [TIME_W-1:0] leave_w;
	logic [CELL_W-1:0] c_w;
	logic              edge_w;
	logic [TIME_W:0]   nb_w;
	logic [25:0]       idx_w;

	assign sel_w   = pick_axis(bt_q[0], bt_q[1], bt_q[2]);
	assign leave_w = bt_q[sel_w];
	assign c_w     = cell_q[sel_w];
	assign edge_w  = neg_q[sel_w] ? (c_w == '0) : (({1'b0, c_w} + 9'd1) >= cnt_w[sel_w]);
	assign nb_w    = {1'b0, leave_w} + {1'b0, ct_q[sel_w]};
	assign idx_w   = {9'b0, m1_q} * {17'b0, cnt_w[0]} + {18'b0, cell_q[0]};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				min_q[a]  <= '0;
				size_q[a] <= 31'd65536;
			end
			cells_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_X:  min_q[0] <= cfg_data;
				CFG_MIN_Y:  min_q[1] <= cfg_data;
				CFG_MIN_Z:  min_q[2] <= cfg_data;
				CFG_SIZE_X: size_q[0] <= cfg_data[30:0];
				CFG_SIZE_Y: size_q[1] <= cfg_data[30:0];
				CFG_SIZE_Z: size_q[2] <= cfg_data[30:0];
				CFG_CELLS:  cells_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Capture ray and setup scratch
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			o_q[0] <= s_tdata[31:0];
			o_q[1] <= s_tdata[63:32];
			o_q[2] <= s_tdata[95:64];
			h_q[0] <= s_tdata[127:96];
			h_q[1] <= s_tdata[159:128];
			h_q[2] <= s_tdata[191:160];
		end
		if (cmd.div_start) begin
			dop_q  <= cmd.div_op;
			dneg_q <= dneg_d;
		end
		if (dv_done && dop_q == DOP_T0) t0_q <= sq_w;
		if (cmd.nsz)    nsz_q <= nsz_w;
		if (cmd.mul_hi) prod_q <= {1'b0, mh_w};
		if (cmd.mul_lo) prod_q <= prod_q + {17'b0, ml_w[46:16]};
		if (cmd.rel)    rel_q <= h_a[31] ? d50 - $signed({2'b0, prod_q})
		                                 : d50 + $signed({2'b0, prod_q});
		if (cmd.tgt)    tgt_q <= lo42 + $signed({2'b0, kp_w});
		if (cmd.em1) begin
			m1_q <= {9'b0, cell_q[2]} * {8'b0, cnt_w[1]} + {9'b0, cell_q[1]};
		end
		if (cmd.em2) idx_q <= idx_w[23:0];
	end

	// Walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			miss_q   <= 1'b0;
			tn_q     <= '0;
			tf_q     <= '0;
			enter_q  <= '0;
			exit_q   <= '0;
			lv_q     <= '0;
			for (int a = 0; a < 3; a++) begin
				cell_q[a] <= '0;
				neg_q[a]  <= 1'b0;
				bt_q[a]   <= '0;
				ct_q[a]   <= '0;
			end
		end else begin
			if (cmd.init) begin
				tn_q     <= '0;
				tf_q     <= tmax33;
				miss_q   <= 1'b0;
				active_q <= 1'b0;
			end
			if (cmd.zero_chk && (o42 < lo42 || o42 > hi_w)) miss_q <= 1'b1;
			// Divider writeback
			if (dv_done) begin
				case (dop_q)
					DOP_T1: begin
						if (nn_w > tn_q) tn_q <= nn_w;
						if (ff_w < tf_q) tf_q <= ff_w;
					end
					DOP_CELL: cell_q[ax] <= dv_quot[CELL_W-1:0];
					DOP_CT:   ct_q[ax] <= dv_quot[31] ? TMAX : dv_quot[30:0];
					DOP_BT: begin
						if (sq_w[32])      bt_q[ax] <= '0;
						else if (sq_w[31]) bt_q[ax] <= TMAX;
						else               bt_q[ax] <= sq_w[30:0];
					end
					default: ;
				endcase
			end
			if (cmd.cell_dir) cell_q[ax] <= rel_q[49] ? '0 : CELL_W'(cnt_a - 9'd1);
			if (cmd.tgt) begin
				neg_q[ax] <= !pos_w;
				if (h_zero) begin
					ct_q[ax] <= TMAX;
					bt_q[ax] <= TMAX;
				end
			end
			if (cmd.commit) begin
				enter_q  <= tn_q[30:0];
				exit_q   <= tf_q[30:0];
				active_q <= 1'b1;
			end
			// Cross the nearest boundary, or drop the ray at the grid edge
			if (cmd.step) begin
				if (edge_w) begin
					active_q <= 1'b0;
					lv_q     <= leave_w;
				end else begin
					cell_q[sel_w] <= neg_q[sel_w] ? c_w - 8'd1 : c_w + 8'd1;
					enter_q       <= leave_w;
					bt_q[sel_w]   <= nb_w[TIME_W] ? TMAX : nb_w[TIME_W-1:0];
				end
			end
			if (cmd.em1) lv_q <= leave_w;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (cmd.out_load) begin
			mv_q <= 1'b1;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mu_q <= cmd.out_kind;
			case (cmd.out_kind)
				WS_VOXEL: md_q <= {3'b0, exit_q, lv_q, enter_q,
				                   cell_q[2], cell_q[1], cell_q[0], idx_q};
				WS_LEFT:  md_q <= {3'b0, exit_q, lv_q, lv_q, 48'b0};
				default:  md_q <= '0;
			endcase
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata  = md_q;
	assign m_tuser  = mu_q;

	// Status
	assign st.req_start   = !s_tuser;
	assign st.h_zero      = h_zero;
	assign st.miss        = miss_q || (tn_q > tf_q) || (tn_q > tmax33);
	assign st.cell_direct = rel_q[49] || (rel_q >= $signed({10'b0, nsz_q}));
	assign st.active      = active_q;
	assign st.edge_hit    = edge_w;
	assign st.out_free    = !mv_q || m_tready;
	assign st.div_done    = dv_done;
	assign st.div_busy    = dv_busy;

endmodule
